### rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the websocket frame deframer
// no dependencies

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic       KIND_HEADER  = 1'b0;
  localparam logic       KIND_PAYLOAD = 1'b1;

  localparam logic [3:0] OPC_CONT     = 4'd0;
  localparam logic [3:0] OPC_BINARY   = 4'd2;

  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic        masked;
    logic [63:0] payload_length;
    logic        is_binary;
    logic        last_of_frame;
  } result_t;

endpackage

### rtl/wsd_front.sv
`timescale 1ns / 1ps
// front end: header parser, classifies each stream byte and emits result entries
// depends on wsd_pkg

module wsd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       stream_byte,
  output logic             push,
  output wsd_pkg::result_t push_item
);
  import wsd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  ext_count, ext_count_next;
  logic [3:0]  hdr_opcode, hdr_opcode_next;
  logic        hdr_fin, hdr_fin_next;
  logic [2:0]  hdr_rsv, hdr_rsv_next;
  logic        hdr_masked, hdr_masked_next;
  logic [63:0] frame_len, frame_len_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_idx, mask_idx_next;
  logic        msg_binary, msg_binary_next;

  logic        len_done;
  logic        hdr_done;
  logic        len_zero;
  logic        cur_bin;
  logic [7:0]  key_sel;

  assign cur_bin = (hdr_opcode == OPC_BINARY) || ((hdr_opcode == OPC_CONT) && msg_binary);

  always_comb begin
    case (mask_idx)
      2'd0:    key_sel = mask_key[31:24];
      2'd1:    key_sel = mask_key[23:16];
      2'd2:    key_sel = mask_key[15:8];
      default: key_sel = mask_key[7:0];
    endcase
  end

  // register next values and result entries
  always_comb begin
    ext_count_next  = ext_count;
    hdr_opcode_next = hdr_opcode;
    hdr_fin_next    = hdr_fin;
    hdr_rsv_next    = hdr_rsv;
    hdr_masked_next = hdr_masked;
    frame_len_next  = frame_len;
    bytes_left_next = bytes_left;
    mask_key_next   = mask_key;
    mask_idx_next   = mask_idx;
    msg_binary_next = msg_binary;
    len_done        = 1'b0;
    hdr_done        = 1'b0;
    push            = 1'b0;
    push_item       = '0;
    if (accept) begin
      case (phase)
        PH_SECOND: begin
          hdr_masked_next = stream_byte[7];
          frame_len_next  = '0;
          if (stream_byte[6:0] == LEN_EXT16) begin
            ext_count_next = EXT16_BYTES;
          end else if (stream_byte[6:0] == LEN_EXT64) begin
            ext_count_next = EXT64_BYTES;
          end else begin
            frame_len_next = {57'd0, stream_byte[6:0]};
            len_done       = 1'b1;
          end
        end
        PH_EXTLEN: begin
          frame_len_next = {frame_len[55:0], stream_byte};
          ext_count_next = ext_count - 4'd1;
          len_done       = (ext_count == 4'd1);
        end
        PH_KEY: begin
          mask_key_next  = {mask_key[23:0], stream_byte};
          ext_count_next = ext_count - 4'd1;
          hdr_done       = (ext_count == 4'd1);
        end
        PH_PAYLOAD: begin
          push                     = 1'b1;
          push_item.kind           = KIND_PAYLOAD;
          push_item.raw_byte       = stream_byte;
          push_item.key_byte       = hdr_masked ? key_sel : 8'd0;
          push_item.opcode         = hdr_opcode;
          push_item.fin            = hdr_fin;
          push_item.rsv            = hdr_rsv;
          push_item.masked         = hdr_masked;
          push_item.payload_length = frame_len;
          push_item.is_binary      = cur_bin;
          push_item.last_of_frame  = (bytes_left == 64'd1);
          mask_idx_next            = mask_idx + 2'd1;
          bytes_left_next          = bytes_left - 64'd1;
        end
        default: begin
          hdr_fin_next    = stream_byte[7];
          hdr_rsv_next    = stream_byte[6:4];
          hdr_opcode_next = stream_byte[3:0];
        end
      endcase
      if (len_done) begin
        if (hdr_masked_next) begin
          mask_key_next  = '0;
          ext_count_next = KEY_BYTES;
        end else begin
          hdr_done = 1'b1;
        end
      end
      if (hdr_done) begin
        if (!hdr_opcode[3]) begin
          msg_binary_next = cur_bin;
        end
        push                     = 1'b1;
        push_item.kind           = KIND_HEADER;
        push_item.raw_byte       = 8'd0;
        push_item.key_byte       = 8'd0;
        push_item.opcode         = hdr_opcode;
        push_item.fin            = hdr_fin;
        push_item.rsv            = hdr_rsv;
        push_item.masked         = hdr_masked_next;
        push_item.payload_length = frame_len_next;
        push_item.is_binary      = cur_bin;
        push_item.last_of_frame  = (frame_len_next == 64'd0);
        bytes_left_next          = frame_len_next;
        mask_idx_next            = 2'd0;
      end
    end
  end

  assign len_zero = (frame_len_next == 64'd0);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_SECOND, PH_EXTLEN: begin
          if (len_done) begin
            if (hdr_masked_next) begin
              phase_next = PH_KEY;
            end else begin
              phase_next = len_zero ? PH_FIRST : PH_PAYLOAD;
            end
          end else begin
            phase_next = PH_EXTLEN;
          end
        end
        PH_KEY: begin
          if (hdr_done) begin
            phase_next = len_zero ? PH_FIRST : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left == 64'd1) begin
            phase_next = PH_FIRST;
          end
        end
        default: phase_next = PH_SECOND;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      ext_count  <= '0;
      hdr_opcode <= '0;
      hdr_fin    <= 1'b0;
      hdr_rsv    <= '0;
      hdr_masked <= 1'b0;
      frame_len  <= '0;
      bytes_left <= '0;
      mask_key   <= '0;
      mask_idx   <= '0;
      msg_binary <= 1'b0;
    end else begin
      phase      <= phase_next;
      ext_count  <= ext_count_next;
      hdr_opcode <= hdr_opcode_next;
      hdr_fin    <= hdr_fin_next;
      hdr_rsv    <= hdr_rsv_next;
      hdr_masked <= hdr_masked_next;
      frame_len  <= frame_len_next;
      bytes_left <= bytes_left_next;
      mask_key   <= mask_key_next;
      mask_idx   <= mask_idx_next;
      msg_binary <= msg_binary_next;
    end
  end

  a_payload_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != 64'd0))
    else $error("payload phase with no bytes left");

  a_ext_count_live: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_EXTLEN) || (phase == PH_KEY)) |-> (ext_count != 4'd0))
    else $error("extension phase with zero byte count");

  a_empty_frame_ends: assert property (@(posedge clk) disable iff (rst)
    (push && (push_item.kind == KIND_HEADER) && push_item.last_of_frame)
      |=> (phase == PH_FIRST))
    else $error("empty frame did not return to first header byte");

endmodule

### rtl/wsd_queue.sv
`timescale 1ns / 1ps
// short result queue between parser front end and output back end
// depends on wsd_pkg

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_item,
  input  logic             pop,
  output wsd_pkg::result_t head,
  output logic             not_empty,
  output logic             full
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### rtl/wsd_back.sv
`timescale 1ns / 1ps
// back end: unmasks payload bytes and holds the result register
// depends on wsd_pkg

module wsd_back (
  input  logic             clk,
  input  logic             rst,
  input  wsd_pkg::result_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic [3:0]       opcode,
  output logic             fin,
  output logic [2:0]       rsv,
  output logic             masked,
  output logic [63:0]      payload_length,
  output logic             is_binary,
  output logic             last_of_frame
);
  import wsd_pkg::*;

  assign pop = head_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind           <= head.kind;
      data_byte      <= head.raw_byte ^ head.key_byte;
      opcode         <= head.opcode;
      fin            <= head.fin;
      rsv            <= head.rsv;
      masked         <= head.masked;
      payload_length <= head.payload_length;
      is_binary      <= head.is_binary;
      last_of_frame  <= head.last_of_frame;
    end
  end

  a_header_no_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_HEADER)) |-> (data_byte == 8'd0))
    else $error("header result carries data");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> !$past(pop))
    else $error("result register loaded while stalled");

  a_empty_header_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_HEADER) && (payload_length == 64'd0))
      |-> last_of_frame)
    else $error("empty frame header not marked last");

endmodule

### rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// top level of the websocket frame deframer
// depends on wsd_pkg, wsd_front, wsd_queue, wsd_back

// Takes one stream byte per clock, unless stream_stall is high, and parses
// RFC 6455 frame headers (flags, opcode, 7/16/64-bit length, optional mask
// key). The byte that completes a header yields one header result; each
// payload byte yields one unmasked result, with last_of_frame on the final
// result of the frame. Throughput is one byte per cycle while not stalled;
// results pass through the QUEUE_DEPTH entry result queue into the result
// register, and stream_stall rises only when that queue is full because
// result_stall has held results back. Other header bytes produce no result.

module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  opcode,
  output logic        fin,
  output logic [2:0]  rsv,
  output logic        masked,
  output logic [63:0] payload_length,
  output logic        is_binary,
  output logic        last_of_frame
);
  import wsd_pkg::*;

  logic    accept;
  logic    push;
  result_t push_item;
  result_t head;
  logic    head_valid;
  logic    full;
  logic    pop;

  assign stream_stall = full;
  assign accept       = stream_valid && !full;

  wsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream_byte),
    .push        (push),
    .push_item   (push_item)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (full)
  );

  wsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .opcode         (opcode),
    .fin            (fin),
    .rsv            (rsv),
    .masked         (masked),
    .payload_length (payload_length),
    .is_binary      (is_binary),
    .last_of_frame  (last_of_frame)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for websocket_frame_deframer: directed and random frames
// checked against a frame parser kept here; depends on wsd_pkg and the deframer rtl

module testbench;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIRECTED_LEN = 25;
  localparam int RANDOM_BYTES = 1400;
  localparam int CALM_AFTER   = 1250;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [3:0] OPC_TEXT    = 4'd1;
  localparam logic [3:0] OPC_RSVD_LO = 4'd3;
  localparam logic [3:0] OPC_RSVD_HI = 4'd7;
  localparam logic [3:0] OPC_CTRL_LO = 4'd8;
  localparam logic [3:0] OPC_CTRL_HI = 4'd15;

  typedef enum int {ENC_7BIT, ENC_16BIT, ENC_64BIT} len_enc_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic        masked;
    logic [63:0] payload_length;
    logic        is_binary;
    logic        last_of_frame;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        stream_valid = 1'b0;
  logic        stream_stall;
  logic [7:0]  stream_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [3:0]  opcode;
  logic        fin;
  logic [2:0]  rsv;
  logic        masked;
  logic [63:0] payload_length;
  logic        is_binary;
  logic        last_of_frame;

  websocket_frame_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .stream_valid   (stream_valid),
    .stream_stall   (stream_stall),
    .stream_byte    (stream_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .opcode         (opcode),
    .fin            (fin),
    .rsv            (rsv),
    .masked         (masked),
    .payload_length (payload_length),
    .is_binary      (is_binary),
    .last_of_frame  (last_of_frame)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state mirrored from the block
  phase_t      p_phase   = PH_FIRST;
  logic [3:0]  p_ext     = 4'd0;
  logic [3:0]  p_opc     = 4'd0;
  logic        p_fin     = 1'b0;
  logic [2:0]  p_rsv     = 3'd0;
  logic        p_masked  = 1'b0;
  logic [63:0] p_len     = 64'd0;
  logic [63:0] p_left    = 64'd0;
  logic [31:0] p_key     = 32'd0;
  logic [1:0]  p_idx     = 2'd0;
  logic        p_msg_bin = 1'b0;

  frame_result_t pending_results[$];
  frame_result_t stim_want = '0;
  bit            stim_typed = 1'b0;

  int  mismatches;
  int  header_results;
  int  payload_results;
  int  bytes_sent;
  int  frames_sent;
  int  cycles;
  int  idle_pct = 20;
  int  stall_pct = 20;
  int  hold_left;
  bit  calm;

  logic [7:0]    directed_bytes [DIRECTED_LEN] = '{
    8'h82, 8'h00,                                     // empty binary frame
    8'h72, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A,  // fragment, all rsv, masked
    8'h8F, 8'h7E, 8'h00, 8'h00,                       // control, 16-bit zero length
    8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  // continuation, 64-bit length
    8'h00, 8'h00, 8'h02, 8'h00, 8'hFF
  };
  bit            typed_row  [DIRECTED_LEN];
  frame_result_t typed_want [DIRECTED_LEN];

  function automatic logic binary_now();
    if (p_opc == OPC_BINARY) return 1'b1;
    if (p_opc == OPC_CONT) return p_msg_bin;
    return 1'b0;
  endfunction

  function automatic frame_result_t result_of(input logic k, input logic [7:0] d,
                                              input logic last);
    return {k, d, p_opc, p_fin, p_rsv, p_masked, p_len, binary_now(), last};
  endfunction

  task automatic header_known(output bit got, output frame_result_t res);
    if (p_opc < OPC_CTRL_LO) p_msg_bin = binary_now();
    res = result_of(KIND_HEADER, 8'h00, p_len == 64'd0);
    got = 1'b1;
    p_left = p_len;
    p_idx = 2'd0;
    p_phase = (p_len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
  endtask

  task automatic length_known(output bit got, output frame_result_t res);
    got = 1'b0;
    res = '0;
    if (p_masked) begin
      p_key = 32'd0;
      p_ext = KEY_BYTES;
      p_phase = PH_KEY;
    end else begin
      header_known(got, res);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_result_t res);
    logic [7:0] key_byte;
    got = 1'b0;
    res = '0;
    case (p_phase)
      PH_SECOND: begin
        p_masked = b[7];
        p_len = 64'd0;
        if (b[6:0] == LEN_EXT16) begin
          p_ext = EXT16_BYTES;
          p_phase = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          p_ext = EXT64_BYTES;
          p_phase = PH_EXTLEN;
        end else begin
          p_len = {57'd0, b[6:0]};
          length_known(got, res);
        end
      end
      PH_EXTLEN: begin
        p_len = {p_len[55:0], b};
        p_ext = p_ext - 4'd1;
        if (p_ext == 4'd0) length_known(got, res);
      end
      PH_KEY: begin
        p_key = {p_key[23:0], b};
        p_ext = p_ext - 4'd1;
        if (p_ext == 4'd0) header_known(got, res);
      end
      PH_PAYLOAD: begin
        key_byte = p_masked ? p_key[31 - 8 * int'(p_idx) -: 8] : 8'h00;
        res = result_of(KIND_PAYLOAD, b ^ key_byte, p_left == 64'd1);
        got = 1'b1;
        p_idx = p_idx + 2'd1;
        p_left = p_left - 64'd1;
        if (p_left == 64'd0) p_phase = PH_FIRST;
      end
      default: begin
        p_fin = b[7];
        p_rsv = b[6:4];
        p_opc = b[3:0];
        p_phase = PH_SECOND;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, seen, want);
  endtask

  task automatic compare_result(input frame_result_t seen);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no transaction pending", 64'(seen.data_byte), 64'd0);
      return;
    end
    want = pending_results.pop_front();
    if (want.kind == KIND_HEADER) header_results++;
    else payload_results++;
    if (seen.kind !== want.kind)
      report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
    if (seen.data_byte !== want.data_byte)
      report_mismatch("data_byte", 64'(seen.data_byte), 64'(want.data_byte));
    if (seen.opcode !== want.opcode)
      report_mismatch("opcode", 64'(seen.opcode), 64'(want.opcode));
    if (seen.fin !== want.fin)
      report_mismatch("fin", 64'(seen.fin), 64'(want.fin));
    if (seen.rsv !== want.rsv)
      report_mismatch("rsv", 64'(seen.rsv), 64'(want.rsv));
    if (seen.masked !== want.masked)
      report_mismatch("masked", 64'(seen.masked), 64'(want.masked));
    if (seen.payload_length !== want.payload_length)
      report_mismatch("payload_length", seen.payload_length, want.payload_length);
    if (seen.is_binary !== want.is_binary)
      report_mismatch("is_binary", 64'(seen.is_binary), 64'(want.is_binary));
    if (seen.last_of_frame !== want.last_of_frame)
      report_mismatch("last_of_frame", 64'(seen.last_of_frame), 64'(want.last_of_frame));
  endtask

  // predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    frame_result_t predicted;
    bit got;
    if (!rst) begin
      if (stream_valid && !stream_stall) begin
        deframe_byte(stream_byte, got, predicted);
        if (got) pending_results.push_back(stim_typed ? stim_want : predicted);
      end
      if (result_valid && !result_stall)
        compare_result({kind, data_byte, opcode, fin, rsv, masked, payload_length,
                        is_binary, last_of_frame});
    end
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (hold_left == 0 && !calm && !rst && $urandom_range(99) < stall_pct)
      hold_left = $urandom_range(16, 1);
    result_stall <= (hold_left != 0);
    if (hold_left != 0) hold_left--;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("websocket_frame_deframer verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    int gap;
    if (!calm && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(16, 1);
      stream_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte <= b;
    stim_typed <= typed;
    stim_want <= want;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first, input logic mask_on,
                            input logic [63:0] len, input len_enc_t enc, input int body);
    logic [31:0] key;
    key = $urandom;
    send_byte(first, 1'b0, '0);
    case (enc)
      ENC_7BIT: send_byte({mask_on, len[6:0]}, 1'b0, '0);
      ENC_16BIT: begin
        send_byte({mask_on, LEN_EXT16}, 1'b0, '0);
        send_byte(len[15:8], 1'b0, '0);
        send_byte(len[7:0], 1'b0, '0);
      end
      default: begin
        send_byte({mask_on, LEN_EXT64}, 1'b0, '0);
        for (int k = 7; k >= 0; k--) send_byte(len[8 * k +: 8], 1'b0, '0);
      end
    endcase
    if (mask_on)
      for (int k = 3; k >= 0; k--) send_byte(key[8 * k +: 8], 1'b0, '0);
    for (int p = 0; p < body; p++) send_byte(8'($urandom_range(255)), 1'b0, '0);
    frames_sent++;
  endtask

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    logic [3:0]  opc;
    logic [2:0]  flags;
    logic [63:0] len;
    len_enc_t    enc;
    int          r;
    int          drain;

    // field order: kind, data, opcode, fin, rsv, masked, length, binary, last
    typed_want[1]  = {KIND_HEADER, 8'h00, OPC_BINARY, 1'b1, 3'd0, 1'b0, 64'd0, 1'b1, 1'b1};
    typed_want[8]  = {KIND_PAYLOAD, 8'hA5, OPC_BINARY, 1'b0, 3'd7, 1'b1, 64'd1, 1'b1, 1'b1};
    typed_want[12] = {KIND_HEADER, 8'h00, OPC_CTRL_HI, 1'b1, 3'd0, 1'b0, 64'd0, 1'b0, 1'b1};
    typed_row[1]  = 1'b1;
    typed_row[8]  = 1'b1;
    typed_row[12] = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_byte(directed_bytes[i], typed_row[i], typed_row[i] ? typed_want[i] : '0);

    while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES) begin
      if (bytes_sent >= DIRECTED_LEN + CALM_AFTER) calm = 1'b1;
      if (frames_sent % 40 == 0) begin
        idle_pct = pick_pct();
        stall_pct = pick_pct();
      end
      r = $urandom_range(99);
      if (r < 30) opc = OPC_CONT;
      else if (r < 55) opc = OPC_BINARY;
      else if (r < 65) opc = OPC_TEXT;
      else if (r < 72) opc = 4'($urandom_range(OPC_RSVD_HI, OPC_RSVD_LO));
      else opc = 4'($urandom_range(OPC_CTRL_HI, OPC_CTRL_LO));
      flags = ($urandom_range(99) < 80) ? 3'd0 : 3'($urandom_range(7));
      r = $urandom_range(99);
      if (r < 85) len = 64'($urandom_range(12));
      else if (r < 97) len = 64'($urandom_range(130, 13));
      else len = 64'($urandom_range(300, 131));
      if (len <= 64'd125 && $urandom_range(99) < 70) enc = ENC_7BIT;
      else if ($urandom_range(1) == 0) enc = ENC_16BIT;
      else enc = ENC_64BIT;
      send_frame({1'($urandom_range(1)), flags, opc}, 1'($urandom_range(1)), len, enc,
                 int'(len));
    end

    // length with its top bit set: only the header and a few payload bytes are sent
    send_frame({1'b1, 3'd5, OPC_BINARY}, 1'b1, 64'h8000_0000_0000_0005, ENC_64BIT, 6);
    stream_valid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never produced", 64'(pending_results.size()), 64'd0);

    $display("covered %0d stream bytes in %0d random frames plus directed ones;",
             bytes_sent, frames_sent);
    $display("compared %0d header and %0d payload results, %0d mismatches",
             header_results, payload_results, mismatches);
    if (mismatches == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
